// ----- design/assert_macros.svh -----
// assertion macros shared by the radius accretion filter rtl
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RAF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

`define RAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define RAF_ASSERT(label, clk, rst_n, prop)

`define RAF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/raf_pkg.sv -----
// types, constants and helpers for the radius accretion filter
// no dependencies
package raf_pkg;

    localparam int VAL_W    = 32;
    localparam int PROD_W   = 64;
    localparam int MASS_W   = 48;
    localparam int CNT_W    = 17;
    localparam int IN_TDATA_W  = 224;
    localparam int OUT_TDATA_W = 264;

    // table length limit; the count saturates at this or at the count field maximum
    localparam int MAX_PARTICLES = 65536;
    localparam int CNT_FIELD_MAX = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] COUNT_CAP =
        CNT_W'((MAX_PARTICLES < CNT_FIELD_MAX) ? MAX_PARTICLES : CNT_FIELD_MAX);

    localparam logic [VAL_W-1:0] RADIUS_LIMIT_RST = 32'h0001_0000;

    typedef enum logic [0:0] {
        REG_RADIUS_LIMIT = 1'b0,
        REG_ACC_ENABLE   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] pos_x;
        logic signed [VAL_W-1:0] pos_y;
        logic signed [VAL_W-1:0] pos_z;
        logic signed [VAL_W-1:0] vel_x;
        logic signed [VAL_W-1:0] vel_y;
        logic signed [VAL_W-1:0] vel_z;
        logic        [VAL_W-1:0] mass;
        logic                    last;
    } particle_t;

    // products of one particle
    typedef struct packed {
        logic        [PROD_W-2:0] sq_x;
        logic        [PROD_W-2:0] sq_y;
        logic        [PROD_W-2:0] sq_z;
        logic        [PROD_W-1:0] lim2;
        logic signed [PROD_W-1:0] p_yz;
        logic signed [PROD_W-1:0] p_zy;
        logic signed [PROD_W-1:0] p_zx;
        logic signed [PROD_W-1:0] p_xz;
        logic signed [PROD_W-1:0] p_xy;
        logic signed [PROD_W-1:0] p_yx;
        logic        [VAL_W-1:0]  mass;
        logic                     last;
    } prod_t;

    // reduced terms ready for the accumulate step
    typedef struct packed {
        logic        [PROD_W-1:0] r2;
        logic        [PROD_W-1:0] lim2;
        logic signed [PROD_W-1:0] cross_x;
        logic signed [PROD_W-1:0] cross_y;
        logic signed [PROD_W-1:0] cross_z;
        logic        [VAL_W-1:0]  mass;
        logic                     last;
    } term_t;

    function automatic logic signed [PROD_W-1:0] sat_add64(
        input logic signed [PROD_W-1:0] a,
        input logic signed [PROD_W-1:0] b
    );
        logic signed [PROD_W:0] s;
        logic signed [PROD_W-1:0] r;
        s = {a[PROD_W-1], a} + {b[PROD_W-1], b};
        if (s[PROD_W] != s[PROD_W-1])
        begin
            r = s[PROD_W] ? {1'b1, {(PROD_W-1){1'b0}}} : {1'b0, {(PROD_W-1){1'b1}}};
        end
        else
        begin
            r = s[PROD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [MASS_W-1:0] sat_add_mass(
        input logic [MASS_W-1:0] a,
        input logic [VAL_W-1:0]  b
    );
        logic [MASS_W:0] s;
        s = {1'b0, a} + (MASS_W+1)'(b);
        return s[MASS_W] ? {MASS_W{1'b1}} : s[MASS_W-1:0];
    endfunction

endpackage

// ----- design/radius_accretion_filter_core.sv -----
// radius accretion filter top level: keep/accrete decision and accumulators
// depends on raf_pkg and assert_macros.svh
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-----------------------------------------
//  s_*      | in  | s_tvalid / s_tready | particle in s_tdata, table end in s_tlast
//  m_*      | out | m_tvalid / m_tready | counts and sums in m_tdata, kept in m_tuser
//  cfg_*    | in  | cfg_we              | register index and write data
//
// one particle per cycle sustained while m_tready stays high; an input beat passes the input register,
// multiplier stage, adder stage and accumulate/result register before it shows as an output beat
// the accumulate step closes a loop on the running sums, which sets the rate
// rst_n clears the stage valids, the accumulators and the count, and resets the cfg registers
// a stall on m_tready holds the sums; empty stages still take beats until all fill
`include "assert_macros.svh"

module radius_accretion_filter_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, mass (32 bits each)
    input  logic [raf_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tvalid,
    input  logic                                s_tlast,
    output logic                                s_tready,
    // kept_count(17), accreted_mass_out(48), ang_mom_x/y/z_out(64 each), zero pad
    output logic [raf_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // kept
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  raf_pkg::cfg_reg_t                   cfg_index,
    input  logic [raf_pkg::VAL_W-1:0]           cfg_data
);
    import raf_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - CNT_W - MASS_W - 3 * PROD_W;

    logic [VAL_W-1:0] radius_limit_reg;
    logic             acc_enable_reg;

    logic             s1_valid_reg;
    particle_t        s1_reg;
    logic             s2_valid_reg;
    prod_t            s2_reg;
    prod_t            s2_next;
    logic             s3_valid_reg;
    term_t            s3_reg;
    term_t            s3_next;

    logic                    m_valid_reg;
    logic                    m_kept_reg;
    logic [CNT_W-1:0]        m_count_reg;
    logic [MASS_W-1:0]       m_mass_reg;
    logic signed [PROD_W-1:0] m_amx_reg;
    logic signed [PROD_W-1:0] m_amy_reg;
    logic signed [PROD_W-1:0] m_amz_reg;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [MASS_W-1:0]        mass_acc_reg;
    logic [MASS_W-1:0]        mass_acc_next;
    logic signed [PROD_W-1:0] amx_reg;
    logic signed [PROD_W-1:0] amx_next;
    logic signed [PROD_W-1:0] amy_reg;
    logic signed [PROD_W-1:0] amy_next;
    logic signed [PROD_W-1:0] amz_reg;
    logic signed [PROD_W-1:0] amz_next;
    logic                     keep;

    logic out_load;
    logic s3_move;
    logic s3_load;
    logic s2_load;
    logic s1_load;

    particle_t in_item;

    // bubbles collapse: a stage loads when empty or when its content moves on
    assign out_load = !m_valid_reg || m_tready;
    assign s3_move  = s3_valid_reg && out_load;
    assign s3_load  = !s3_valid_reg || out_load;
    assign s2_load  = !s2_valid_reg || s3_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign s_tready = s1_load;

    always_comb
    begin
        in_item.pos_x = s_tdata[31:0];
        in_item.pos_y = s_tdata[63:32];
        in_item.pos_z = s_tdata[95:64];
        in_item.vel_x = s_tdata[127:96];
        in_item.vel_y = s_tdata[159:128];
        in_item.vel_z = s_tdata[191:160];
        in_item.mass  = s_tdata[223:192];
        in_item.last  = s_tlast;
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_limit_reg <= RADIUS_LIMIT_RST;
            acc_enable_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS_LIMIT: radius_limit_reg <= cfg_data;
                REG_ACC_ENABLE:   acc_enable_reg   <= cfg_data[0];
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && s_tvalid)
        begin
            s1_reg <= in_item;
        end
    end

    // multiplier stage: squares are at most 2^62 so they fit in 63 bits
    always_comb
    begin
        logic signed [PROD_W-1:0] sx;
        logic signed [PROD_W-1:0] sy;
        logic signed [PROD_W-1:0] sz;
        sx = PROD_W'(s1_reg.pos_x) * PROD_W'(s1_reg.pos_x);
        sy = PROD_W'(s1_reg.pos_y) * PROD_W'(s1_reg.pos_y);
        sz = PROD_W'(s1_reg.pos_z) * PROD_W'(s1_reg.pos_z);
        s2_next.sq_x = sx[PROD_W-2:0];
        s2_next.sq_y = sy[PROD_W-2:0];
        s2_next.sq_z = sz[PROD_W-2:0];
        s2_next.lim2 = PROD_W'(radius_limit_reg) * PROD_W'(radius_limit_reg);
        s2_next.p_yz = PROD_W'(s1_reg.pos_y) * PROD_W'(s1_reg.vel_z);
        s2_next.p_zy = PROD_W'(s1_reg.pos_z) * PROD_W'(s1_reg.vel_y);
        s2_next.p_zx = PROD_W'(s1_reg.pos_z) * PROD_W'(s1_reg.vel_x);
        s2_next.p_xz = PROD_W'(s1_reg.pos_x) * PROD_W'(s1_reg.vel_z);
        s2_next.p_xy = PROD_W'(s1_reg.pos_x) * PROD_W'(s1_reg.vel_y);
        s2_next.p_yx = PROD_W'(s1_reg.pos_y) * PROD_W'(s1_reg.vel_x);
        s2_next.mass = s1_reg.mass;
        s2_next.last = s1_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    // adder stage: radius sum and cross differences are exact in 64 bits
    always_comb
    begin
        s3_next.r2 = PROD_W'(s2_reg.sq_x) + PROD_W'(s2_reg.sq_y) + PROD_W'(s2_reg.sq_z);
        s3_next.lim2    = s2_reg.lim2;
        s3_next.cross_x = s2_reg.p_yz - s2_reg.p_zy;
        s3_next.cross_y = s2_reg.p_zx - s2_reg.p_xz;
        s3_next.cross_z = s2_reg.p_xy - s2_reg.p_yx;
        s3_next.mass    = s2_reg.mass;
        s3_next.last    = s2_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_load)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_load && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    // accumulate step
    always_comb
    begin
        keep          = s3_reg.r2 >= s3_reg.lim2;
        count_next    = count_reg;
        mass_acc_next = mass_acc_reg;
        amx_next      = amx_reg;
        amy_next      = amy_reg;
        amz_next      = amz_reg;
        if (keep)
        begin
            if (count_reg < COUNT_CAP)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (acc_enable_reg)
        begin
            mass_acc_next = sat_add_mass(mass_acc_reg, s3_reg.mass);
            amx_next      = sat_add64(amx_reg, s3_reg.cross_x);
            amy_next      = sat_add64(amy_reg, s3_reg.cross_y);
            amz_next      = sat_add64(amz_reg, s3_reg.cross_z);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            mass_acc_reg <= '0;
            amx_reg      <= '0;
            amy_reg      <= '0;
            amz_reg      <= '0;
        end
        else if (s3_move)
        begin
            // the result of the table's last particle still shows the full count
            count_reg    <= s3_reg.last ? '0 : count_next;
            mass_acc_reg <= mass_acc_next;
            amx_reg      <= amx_next;
            amy_reg      <= amy_next;
            amz_reg      <= amz_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_move)
        begin
            m_kept_reg  <= keep;
            m_count_reg <= count_next;
            m_mass_reg  <= mass_acc_next;
            m_amx_reg   <= amx_next;
            m_amy_reg   <= amy_next;
            m_amz_reg   <= amz_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kept_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_amz_reg, m_amy_reg, m_amx_reg,
                       m_mass_reg, m_count_reg};

    // sums hold while a result is stalled
    `RAF_ASSERT_NEXT(a_sums_hold, clk, rst_n, m_tvalid && !m_tready,
        $stable(mass_acc_reg) && $stable(amx_reg) && $stable(amy_reg) && $stable(amz_reg))
    // accreted mass never decreases
    `RAF_ASSERT_NEXT(a_mass_monotonic, clk, rst_n, 1'b1, mass_acc_reg >= $past(mass_acc_reg))
    // table count stays within its cap
    `RAF_ASSERT(a_count_cap, clk, rst_n, count_reg <= COUNT_CAP)
    // a kept particle always shows a nonzero count
    `RAF_ASSERT(a_kept_counted, clk, rst_n, !(m_tvalid && m_tuser) || (m_count_reg != '0))

endmodule
